/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the contact tracker checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cpct_pkg.sv */
// ---------------------------------------------------------------------------
// cpct_pkg
// Item types, field widths and codes of the collider pair contact tracker.
// ---------------------------------------------------------------------------
package cpct_pkg;

  localparam int ID_W    = 5;
  localparam int COORD_W = 16;
  localparam int SIZE_W  = COORD_W - 1;
  // Doubled positions plus a size and a grown margin stay within this signed width.
  localparam int WIDE_W  = COORD_W + 4;
  // Largest corner distance magnitude, and its square.
  localparam int MAG_W   = COORD_W + 2;
  localparam int SQ_W    = 2 * MAG_W;

  typedef enum logic [1:0] {
    SHAPES_RR = 2'd0,  // rectangle and rectangle
    SHAPES_CR = 2'd1,  // first is a circle, second a rectangle
    SHAPES_RC = 2'd2,  // first is a rectangle, second a circle
    SHAPES_CC = 2'd3   // circle and circle
  } shapes_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BEGIN = 2'd1,
    EV_STAY  = 2'd2,
    EV_END   = 2'd3
  } contact_ev_t;

  typedef struct packed {
    logic [ID_W-1:0]           first_id;
    logic [ID_W-1:0]           second_id;
    shapes_t                   shape_pair;
    logic                      both_enabled;
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_y;
    logic [SIZE_W-1:0]         first_size_x;
    logic [SIZE_W-1:0]         first_size_y;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_y;
    logic [SIZE_W-1:0]         second_size_x;
    logic [SIZE_W-1:0]         second_size_y;
  } in_item_t;

  typedef struct packed {
    logic        touching;
    contact_ev_t contact_event;
  } out_item_t;

endpackage

/* rtl/collider_pair_contact_tracker.sv */
// ---------------------------------------------------------------------------
// collider_pair_contact_tracker
// Box and circle overlap test for an ordered pair of shapes, with a per-pair
// contact memory that turns each test into a none, begin, stay or end event.
// ---------------------------------------------------------------------------
//
//  Channel | Ports                         | Moves
//  --------+-------------------------------+-------------------------------
//  input   | in_valid, in_ready, in_data   | one shape pair item
//  result  | out_valid, out_ready, out_data| touching flag and contact event
//
// An item passes through the accept state, in which the contact row of the
// first collider is read from the memory, then ST_CALC1 for differences and
// box compares, ST_CALC2 for squares, and ST_CALC3, which compares the
// squares and writes the updated row back. Because of that read-modify-write
// of the row, no new item is taken until the last one has written it back.
// After reset all MAX_COLLIDERS rows of the memory are cleared, one row a
// cycle, and in_ready stays low until that pass is done.
// The result register lets the next item be accepted while a result waits;
// a result that is still not taken holds the block in its last work cycle.
//
module collider_pair_contact_tracker #(
  parameter int MAX_COLLIDERS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cpct_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output cpct_pkg::out_item_t out_data
);
  import cpct_pkg::*;

  // One row per first collider, one bit per second collider.
  localparam int ROW_W   = $clog2(MAX_COLLIDERS);
  localparam int NUM_IDS = 2 ** ID_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC1,
    ST_CALC2,
    ST_CALC3
  } state_t;

  // Sign or zero extension into the working width of the geometry.
  function automatic logic signed [WIDE_W-1:0] sx(input logic [COORD_W-1:0] v);
    sx = {{(WIDE_W - COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] zx(input logic [SIZE_W-1:0] v);
    zx = {{(WIDE_W - SIZE_W){1'b0}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] absw(input logic signed [WIDE_W-1:0] v);
    absw = v[WIDE_W-1] ? -v : v;
  endfunction

  // Every distance that reaches a square stays below two to the MAG_W.
  function automatic logic [MAG_W-1:0] mag(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] a;
    a   = absw(v);
    mag = a[MAG_W-1:0];
  endfunction

  function automatic logic [SQ_W-1:0] sq(input logic [MAG_W-1:0] v);
    logic [SQ_W-1:0] w;
    w  = {{MAG_W{1'b0}}, v};
    sq = w * w;
  endfunction

  // -------------------------------------------------------------------------
  // Id reduction. An id is taken modulo MAX_COLLIDERS; the table is built at
  // elaboration, so no divider is needed.
  // -------------------------------------------------------------------------
  logic [ROW_W-1:0] id_mod [NUM_IDS];

  for (genvar g = 0; g < NUM_IDS; g++) begin : g_id_mod
    assign id_mod[g] = ROW_W'(g % MAX_COLLIDERS);
  end

  // -------------------------------------------------------------------------
  // Control and result registers
  // -------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] clr_r, clr_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic in_fire;
  logic out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // -------------------------------------------------------------------------
  // Item registers and the contact memory
  // -------------------------------------------------------------------------
  in_item_t                   pay_r;
  logic [ROW_W-1:0]           row_a_r;
  logic [ROW_W-1:0]           bit_b_r;
  logic [MAX_COLLIDERS-1:0]   row_r;
  logic [MAX_COLLIDERS-1:0]   contact_mem [MAX_COLLIDERS];

  logic [ROW_W-1:0]           rd_row;
  logic                       mem_we;
  logic [ROW_W-1:0]           mem_waddr;
  logic [MAX_COLLIDERS-1:0]   mem_wdata;

  assign rd_row = id_mod[in_data.first_id];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      contact_mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      row_r <= contact_mem[rd_row];
    end
  end

  // -------------------------------------------------------------------------
  // First work cycle: differences, box compares and corner magnitudes.
  // The rectangle and circle of a mixed pair are put in a fixed order, and a
  // circle pair uses the same corner path with the centre difference.
  // -------------------------------------------------------------------------
  logic signed [WIDE_W-1:0] ax, ay, bx, by;
  logic signed [WIDE_W-1:0] aw, ah, bw, bh;
  logic signed [WIDE_W-1:0] rx, ry, rw, rh, cx, cy, cr;
  logic signed [WIDE_W-1:0] lft, rgt, top, bot, px, py, dd;
  logic signed [WIDE_W-1:0] dxc, dyc;
  logic signed [WIDE_W-1:0] cdx [4];
  logic signed [WIDE_W-1:0] cdy [4];
  logic signed [WIDE_W-1:0] cdd;
  logic                     first_rect, circ_pair;
  logic                     rr_hit, span_hit, grown_hit;

  always_comb begin
    ax = sx(pay_r.first_x);
    ay = sx(pay_r.first_y);
    bx = sx(pay_r.second_x);
    by = sx(pay_r.second_y);
    aw = zx(pay_r.first_size_x);
    ah = zx(pay_r.first_size_y);
    bw = zx(pay_r.second_size_x);
    bh = zx(pay_r.second_size_y);

    first_rect = (pay_r.shape_pair == SHAPES_RC);
    circ_pair  = (pay_r.shape_pair == SHAPES_CC);

    rx = first_rect ? ax : bx;
    ry = first_rect ? ay : by;
    rw = first_rect ? aw : bw;
    rh = first_rect ? ah : bh;
    cx = first_rect ? bx : ax;
    cy = first_rect ? by : ay;
    cr = first_rect ? bw : aw;

    // Positions are doubled so that the half sizes stay whole.
    lft = rx + rx - rw;
    rgt = rx + rx + rw;
    top = ry + ry - rh;
    bot = ry + ry + rh;
    px  = cx + cx;
    py  = cy + cy;
    dd  = cr + cr;

    span_hit  = (px >= lft && px <= rgt) || (py >= top && py <= bot);
    grown_hit = px >= lft - dd && px <= rgt + dd && py >= top - dd && py <= bot + dd;

    dxc    = ax - bx;
    dyc    = ay - by;
    rr_hit = (absw(dxc) + absw(dxc) < aw + bw) && (absw(dyc) + absw(dyc) < ah + bh);

    cdx[0] = circ_pair ? dxc : px - lft;
    cdy[0] = circ_pair ? dyc : py - top;
    cdx[1] = circ_pair ? dxc : px - rgt;
    cdy[1] = circ_pair ? dyc : py - top;
    cdx[2] = circ_pair ? dxc : px - lft;
    cdy[2] = circ_pair ? dyc : py - bot;
    cdx[3] = circ_pair ? dxc : px - rgt;
    cdy[3] = circ_pair ? dyc : py - bot;
    cdd    = circ_pair ? aw + bw : dd;
  end

  logic             rr_r, span_r, grown_r;
  logic [MAG_W-1:0] mx_r [4];
  logic [MAG_W-1:0] my_r [4];
  logic [MAG_W-1:0] md_r;
  logic [SQ_W-1:0]  sqx_r [4];
  logic [SQ_W-1:0]  sqy_r [4];
  logic [SQ_W-1:0]  sqd_r;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pay_r   <= in_data;
      row_a_r <= rd_row;
      bit_b_r <= id_mod[in_data.second_id];
    end
    if (state_r == ST_CALC1) begin
      rr_r    <= rr_hit;
      span_r  <= span_hit;
      grown_r <= grown_hit;
      md_r    <= mag(cdd);
      for (int i = 0; i < 4; i++) begin
        mx_r[i] <= mag(cdx[i]);
        my_r[i] <= mag(cdy[i]);
      end
    end
    if (state_r == ST_CALC2) begin
      sqd_r <= sq(md_r);
      for (int i = 0; i < 4; i++) begin
        sqx_r[i] <= sq(mx_r[i]);
        sqy_r[i] <= sq(my_r[i]);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Last work cycle: distance compares, final overlap, event and write-back.
  // -------------------------------------------------------------------------
  logic                     near_hit;
  logic                     geo_hit;
  logic                     hit;
  logic                     prev;
  logic                     ids_differ;
  contact_ev_t              ev;
  logic [MAX_COLLIDERS-1:0] row_upd;

  always_comb begin
    near_hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      near_hit = near_hit ||
                 (({1'b0, sqx_r[i]} + {1'b0, sqy_r[i]}) <= {1'b0, sqd_r});
    end

    case (pay_r.shape_pair)
      SHAPES_RR: geo_hit = rr_r;
      SHAPES_CC: geo_hit = near_hit;
      default:   geo_hit = span_r ? grown_r : near_hit;
    endcase

    hit        = pay_r.both_enabled && geo_hit;
    ids_differ = (pay_r.first_id != pay_r.second_id);
    prev       = row_r[bit_b_r];

    if (hit) begin
      ev = prev ? EV_STAY : EV_BEGIN;
    end else begin
      ev = prev ? EV_END : EV_NONE;
    end

    row_upd          = row_r;
    row_upd[bit_b_r] = hit;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_a_r;
    mem_wdata = row_upd;
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (state_r == ST_CALC3 && out_free && ids_differ) begin
      mem_we = 1'b1;
    end
  end

  // -------------------------------------------------------------------------
  // Sequencer
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ROW_W'(MAX_COLLIDERS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_CALC1;
        end
      end
      ST_CALC1: state_nxt = ST_CALC2;
      ST_CALC2: state_nxt = ST_CALC3;
      ST_CALC3: begin
        if (out_free) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          if (ids_differ) begin
            out_data_nxt.touching      = hit;
            out_data_nxt.contact_event = ev;
          end else begin
            // A pair with itself never touches and leaves the memory alone.
            out_data_nxt.touching      = 1'b0;
            out_data_nxt.contact_event = EV_NONE;
          end
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

endmodule

/* rtl/cpct_checker.sv */
// ---------------------------------------------------------------------------
// cpct_checker
// Port-level checks of the contact tracker, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cpct_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input cpct_pkg::out_item_t out_data
);
  import cpct_pkg::*;

  // A waiting result is neither dropped nor altered.
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result changed while stalled")

  // Only one item is at work at a time.
  `ASSERT_CLK(a_one_item, in_valid && in_ready |=> !in_ready, "item accepted while another is at work")

  // A new result only comes out of a work cycle, never straight from idle.
  `ASSERT_CLK(a_result_from_work, $rose(out_valid) |-> $past(!in_ready), "result without work cycle")

  // The event agrees with the touching flag.
  `ASSERT_CLK(a_event_agrees, out_valid |-> (out_data.touching == (out_data.contact_event == EV_BEGIN || out_data.contact_event == EV_STAY)), "event disagrees with touching")

  // Reset empties the result register and holds off input during clearing.
  `ASSERT_CLK_ALWAYS(a_reset_state, !rst_n |=> !out_valid && !in_ready, "bad state after reset")

endmodule

bind collider_pair_contact_tracker cpct_checker u_cpct_checker (.*);

/* sim/tb_collider_pair_contact_tracker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_collider_pair_contact_tracker
// Self-checking bench for the pair contact tracker. Every shape-pair item
// that the block accepts is run through an independent overlap and contact
// memory model kept in the bench. Each result item is compared field by field
// with the oldest outstanding prediction, under random idling on both sides,
// a long result hold-off and a sender pause.
// ---------------------------------------------------------------------------
module tb_collider_pair_contact_tracker;
  import cpct_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 11;
  localparam int N_COLLIDERS  = 32;
  // Cycles in which no item moves on either channel before the run is abandoned.
  // Well above the long hold-off plus the clearing pass after reset.
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  // Settling time after the last result, longer than the period of one item.
  localparam int DRAIN_CYCLES = 20;
  localparam int UNIT         = 16;  // 1.0 in Q12.4

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  collider_pair_contact_tracker #(
    .MAX_COLLIDERS(N_COLLIDERS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Bench copy of the per-pair contact memory, keyed by the ordered id pair.
  bit        contact_seen [N_COLLIDERS * N_COLLIDERS];
  // Predicted result items, oldest first.
  out_item_t expected_contacts [$];
  int        mismatches    = 0;
  // Chance, in percent, that the sender or the receiver idles in a cycle.
  int        send_idle_pct = 0;
  int        take_idle_pct = 0;
  // Cycles left in a forced hold-off of the result channel.
  int        hold_cycles   = 0;
  // Most recently accepted pair, used to build follow-on movement items.
  in_item_t  last_pair     = '0;

  initial begin : clock_gen
    forever #CLK_HALF clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Overlap and contact prediction
  // -------------------------------------------------------------------------

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // True when the point (dx, dy) lies within distance d of the origin.
  function automatic bit within_reach(input longint dx, dy, d);
    return (dx * dx + dy * dy) <= (d * d);
  endfunction

  // Box given by centre and full size, circle by centre and radius. All work
  // is done on doubled positions so that halving the sizes stays exact.
  function automatic bit box_meets_circle(input longint rx, ry, rw, rh,
                                          input longint cx, cy, r);
    longint lft, rgt, top, bot, x, y, d;
    lft = 2 * rx - rw;
    rgt = 2 * rx + rw;
    top = 2 * ry - rh;
    bot = 2 * ry + rh;
    x   = 2 * cx;
    y   = 2 * cy;
    d   = 2 * r;
    // Centre level with a side: the box grown by the radius decides, edges count.
    if ((x >= lft && x <= rgt) || (y >= top && y <= bot))
      return x >= lft - d && x <= rgt + d && y >= top - d && y <= bot + d;
    // Otherwise the nearest corner must be within the radius.
    return within_reach(x - lft, y - top, d) || within_reach(x - rgt, y - top, d) ||
           within_reach(x - lft, y - bot, d) || within_reach(x - rgt, y - bot, d);
  endfunction

  // Works out the result of one pair and updates the bench contact memory.
  function automatic out_item_t predict_contact(input in_item_t it);
    out_item_t res;
    longint    ax, ay, aw, ah, bx, by, bw, bh;
    bit        hit;
    bit        was;
    int        slot;
    res.touching      = 1'b0;
    res.contact_event = EV_NONE;
    // A collider never collides with itself, and the memory is left alone.
    if (it.first_id == it.second_id)
      return res;
    ax  = longint'(it.first_x);
    ay  = longint'(it.first_y);
    aw  = longint'(it.first_size_x);
    ah  = longint'(it.first_size_y);
    bx  = longint'(it.second_x);
    by  = longint'(it.second_y);
    bw  = longint'(it.second_size_x);
    bh  = longint'(it.second_size_y);
    hit = 1'b0;
    if (it.both_enabled) begin
      case (it.shape_pair)
        SHAPES_RR: begin
          hit = (2 * magnitude(ax - bx) < aw + bw) && (2 * magnitude(ay - by) < ah + bh);
        end
        SHAPES_CC: begin
          hit = within_reach(ax - bx, ay - by, aw + bw);
        end
        SHAPES_RC: begin
          hit = box_meets_circle(ax, ay, aw, ah, bx, by, bw);
        end
        default: begin
          hit = box_meets_circle(bx, by, bw, bh, ax, ay, aw);
        end
      endcase
    end
    slot = (int'(it.first_id) % N_COLLIDERS) * N_COLLIDERS +
           (int'(it.second_id) % N_COLLIDERS);
    was  = contact_seen[slot];
    res.touching = hit;
    if (hit)
      res.contact_event = was ? EV_STAY : EV_BEGIN;
    else
      res.contact_event = was ? EV_END : EV_NONE;
    contact_seen[slot] = hit;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Item construction
  // -------------------------------------------------------------------------

  function automatic in_item_t build_pair(input int a_id, b_id, input shapes_t sh,
                                          input bit en, input int ax, ay, aw, ah,
                                          input int bx, by, bw, bh);
    in_item_t it;
    it.first_id      = ID_W'(a_id);
    it.second_id     = ID_W'(b_id);
    it.shape_pair    = sh;
    it.both_enabled  = en;
    it.first_x       = COORD_W'(ax);
    it.first_y       = COORD_W'(ay);
    it.first_size_x  = SIZE_W'(aw);
    it.first_size_y  = SIZE_W'(ah);
    it.second_x      = COORD_W'(bx);
    it.second_y      = COORD_W'(by);
    it.second_size_x = SIZE_W'(bw);
    it.second_size_y = SIZE_W'(bh);
    return it;
  endfunction

  function automatic int jitter(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Random traffic is mostly shapes that sit near each other, so that contacts
  // begin, stay and end; a tenth of the items are wholly random noise.
  function automatic in_item_t random_pair();
    in_item_t it;
    int       mode;
    int       reach;
    it   = last_pair;
    mode = $urandom_range(0, 99);
    if (mode < 10) begin
      it.first_id      = ID_W'($urandom);
      it.second_id     = ID_W'($urandom);
      it.shape_pair    = shapes_t'(2'($urandom));
      it.both_enabled  = 1'($urandom);
      it.first_x       = COORD_W'($urandom);
      it.first_y       = COORD_W'($urandom);
      it.first_size_x  = SIZE_W'($urandom);
      it.first_size_y  = SIZE_W'($urandom);
      it.second_x      = COORD_W'($urandom);
      it.second_y      = COORD_W'($urandom);
      it.second_size_x = SIZE_W'($urandom);
      it.second_size_y = SIZE_W'($urandom);
    end else if (mode < 55) begin
      // The same pair moves a little, which drives the stay and end events.
      it.first_x      = COORD_W'(int'(it.first_x) + jitter(4 * UNIT));
      it.first_y      = COORD_W'(int'(it.first_y) + jitter(4 * UNIT));
      it.second_x     = COORD_W'(int'(it.second_x) + jitter(4 * UNIT));
      it.second_y     = COORD_W'(int'(it.second_y) + jitter(4 * UNIT));
      it.both_enabled = ($urandom_range(0, 99) >= 5);
    end else begin
      // A fresh pair from a small pool of ids, close enough to overlap often.
      it.first_id      = ID_W'($urandom_range(0, 5));
      it.second_id     = ID_W'($urandom_range(0, 5));
      it.shape_pair    = shapes_t'(2'($urandom));
      it.both_enabled  = ($urandom_range(0, 99) >= 5);
      it.first_x       = COORD_W'($urandom);
      it.first_y       = COORD_W'($urandom);
      it.first_size_x  = SIZE_W'($urandom_range(0, 64 * UNIT));
      it.first_size_y  = SIZE_W'($urandom_range(0, 64 * UNIT));
      it.second_size_x = SIZE_W'($urandom_range(0, 64 * UNIT));
      it.second_size_y = SIZE_W'($urandom_range(0, 64 * UNIT));
      it.second_x      = COORD_W'(int'(it.first_x) + jitter(64 * UNIT));
      it.second_y      = COORD_W'(int'(it.first_y) + jitter(64 * UNIT));
      if ($urandom_range(0, 99) < 20) begin
        // Put the second centre on, or one step off, the touching distance in x.
        reach       = (int'(it.first_size_x) + int'(it.second_size_x)) / 2;
        it.second_x = COORD_W'(int'(it.first_x) + reach + jitter(1));
      end
    end
    return it;
  endfunction

  // -------------------------------------------------------------------------
  // Channel handling
  // -------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Offers one item, after any random idle cycles, and holds it until taken.
  // The prediction is made at the edge at which the item is accepted.
  task automatic send_pair(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    expected_contacts.insert(expected_contacts.size(), predict_contact(it));
    last_pair = it;
  endtask

  // Lowers the input valid and waits until every predicted result has arrived.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result channel ready: random idling, or a forced hold-off when one is asked.
  initial begin : result_taker
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready   <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= take_idle_pct);
      end
    end
  end

  // Compares every accepted result with the oldest prediction. Values are read
  // at the edge, before any update that the edge itself schedules.
  initial begin : result_checker
    out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_contacts.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: touching %0b event %s",
                                    out_data.touching, out_data.contact_event.name()));
        end else begin
          want = expected_contacts.pop_front();
          if (out_data.touching !== want.touching)
            report_mismatch($sformatf("touching %0b, expected %0b",
                                      out_data.touching, want.touching));
          if (out_data.contact_event !== want.contact_event)
            report_mismatch($sformatf("contact_event %s, expected %s",
                                      out_data.contact_event.name(),
                                      want.contact_event.name()));
        end
      end
    end
  end

  // Ends the run when no item has moved on either channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Each shape pairing, the boundaries of every test, equal ids, a disabled
  // pair, the full begin, stay and end cycle and the extremes of the fields.
  task automatic test_directed_cases();
    send_idle_pct = 0;
    take_idle_pct = 30;
    // Boxes overlapping: begin, then stay.
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b1, 0, 0, 64, 64, 32, 0, 64, 64));
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b1, 0, 0, 64, 64, 32, 0, 64, 64));
    // Boxes exactly edge to edge do not touch: end, then none.
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b1, 0, 0, 64, 64, 64, 0, 64, 64));
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b1, 0, 0, 64, 64, 64, 0, 64, 64));
    // Circles exactly at the radius sum touch; one step further they part.
    // The height fields are set high to show that circles ignore them.
    send_pair(build_pair(3, 4, SHAPES_CC, 1'b1, 0, 0, 40, 32767, 48, 64, 40, 32767));
    send_pair(build_pair(3, 4, SHAPES_CC, 1'b1, 0, 0, 40, 32767, 49, 64, 40, 32767));
    // Box then circle: centre level with the box, on the grown edge.
    send_pair(build_pair(5, 6, SHAPES_RC, 1'b1, 0, 0, 32, 32, 96, 0, 80, 0));
    // Circle exactly at the radius from a corner, then one step outside it.
    send_pair(build_pair(5, 6, SHAPES_RC, 1'b1, 0, 0, 32, 32, 64, 80, 80, 0));
    send_pair(build_pair(5, 6, SHAPES_RC, 1'b1, 0, 0, 32, 32, 65, 80, 80, 0));
    // Circle then box, corner hit and then just past the grown edge.
    send_pair(build_pair(7, 8, SHAPES_CR, 1'b1, 64, 80, 80, 5, 0, 0, 32, 32));
    send_pair(build_pair(7, 8, SHAPES_CR, 1'b1, 97, 0, 80, 5, 0, 0, 32, 32));
    // Equal ids on overlapping shapes: no contact and the memory is untouched.
    send_pair(build_pair(1, 1, SHAPES_RR, 1'b1, 0, 0, 64, 64, 0, 0, 64, 64));
    // A contact cut short by a disabled collider ends, then reports none.
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b1, 0, 0, 64, 64, 32, 0, 64, 64));
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b0, 0, 0, 64, 64, 32, 0, 64, 64));
    send_pair(build_pair(1, 2, SHAPES_RR, 1'b0, 0, 0, 64, 64, 32, 0, 64, 64));
    // Extremes: largest boxes at the lowest corner, in both id orders.
    send_pair(build_pair(31, 0, SHAPES_RR, 1'b1, -32768, -32768, 32767, 32767,
                         -32768, -32768, 32767, 32767));
    send_pair(build_pair(0, 31, SHAPES_RR, 1'b1, -32768, -32768, 32767, 32767,
                         -32768, -32768, 32767, 32767));
    // Largest circles at opposite corners, from each other or from a largest box, stay apart.
    send_pair(build_pair(31, 0, SHAPES_CC, 1'b1, -32768, -32768, 32767, 32767,
                         32767, 32767, 32767, 32767));
    send_pair(build_pair(30, 29, SHAPES_RC, 1'b1, 32767, 32767, 32767, 32767,
                         -32768, -32768, 32767, 0));
    send_pair(build_pair(29, 30, SHAPES_CR, 1'b1, 32767, -32768, 32767, 0,
                         -32768, 32767, 32767, 32767));
    // All fields zero, and all fields at their top, both with equal ids.
    send_pair(build_pair(0, 0, SHAPES_RR, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(build_pair(31, 31, SHAPES_CC, 1'b1, 32767, 32767, 32767, 32767,
                         32767, 32767, 32767, 32767));
    // Zero-size shapes on the same spot: boxes miss, circles meet.
    send_pair(build_pair(9, 10, SHAPES_RR, 1'b1, 100, 100, 0, 0, 100, 100, 0, 0));
    send_pair(build_pair(11, 12, SHAPES_CC, 1'b1, 100, 100, 0, 0, 100, 100, 0, 0));
  endtask

  task automatic test_random_traffic(input int count, input int snd_pct, input int rcv_pct);
    send_idle_pct = snd_pct;
    take_idle_pct = rcv_pct;
    repeat (count) send_pair(random_pair());
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // items, so the block fills up and must stall its input.
  task automatic test_long_backpressure();
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_cycles   = LONG_HOLD;
    repeat (30) send_pair(random_pair());
  endtask

  // The sender stops until every outstanding result has come back, then resumes.
  task automatic test_sender_pause();
    send_idle_pct = 10;
    take_idle_pct = 20;
    repeat (20) send_pair(random_pair());
    pause_until_drained();
    repeat (20) send_pair(random_pair());
  endtask

  initial begin : test_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_traffic(320, 25, 61);
    test_random_traffic(320, 61, 25);
    test_random_traffic(300, 0, 0);
    test_long_backpressure();
    test_sender_pause();

    pause_until_drained();
    if (expected_contacts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_contacts.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
